### rtl/core/vdma_pkg.sv
// Package: types, codes and constants of the video-memory DMA controller.
package vdma_pkg;

  localparam int unsigned AddrW = 16;
  localparam int unsigned LenW  = 12;

  // Longest transfer; longer requests saturate here.
  localparam logic [LenW-1:0] MaxLength  = 12'd2048;
  // Bytes per horizontal-blank burst (power of two).
  localparam logic [LenW-1:0] BlockBytes = 12'd16;

  typedef enum logic {
    ModeTick  = 1'b0,
    ModeStart = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    KindNone    = 2'd0,
    KindGeneral = 2'd1,
    KindHblank  = 2'd2
  } kind_e;

  typedef struct packed {
    logic             mode;
    logic [1:0]       start_kind;
    logic [AddrW-1:0] src_addr;
    logic [AddrW-1:0] dest_addr;
    logic [LenW-1:0]  length;
    logic             cpu_halted;
    logic             ppu_in_hblank;
    logic             lcd_enabled;
  } in_item_t;

  typedef struct packed {
    logic             copy_valid;
    logic [AddrW-1:0] copy_src;
    logic [AddrW-1:0] copy_dest;
    logic             cpu_block;
    logic             busy_res;
  } out_item_t;

  typedef struct packed {
    kind_e            kind;
    logic [LenW-1:0]  length;
    logic [LenW-1:0]  offset;
    logic [AddrW-1:0] src_base;
    logic [AddrW-1:0] dest_base;
    logic             block_wait;
    logic             cpu_blocked;
  } state_t;

endpackage

### rtl/core/vdma_if.sv
// Interfaces: input and result channels of the video-memory DMA controller.
interface vdma_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [1:0]  start_kind;
  logic [15:0] src_addr;
  logic [15:0] dest_addr;
  logic [11:0] length;
  logic        cpu_halted;
  logic        ppu_in_hblank;
  logic        lcd_enabled;

  modport source (
    output valid, mode, start_kind, src_addr, dest_addr, length,
           cpu_halted, ppu_in_hblank, lcd_enabled,
    input  ready
  );
  modport sink (
    input  valid, mode, start_kind, src_addr, dest_addr, length,
           cpu_halted, ppu_in_hblank, lcd_enabled,
    output ready
  );
endinterface

interface vdma_out_if;
  logic        valid;
  logic        ready;
  logic        copy_valid;
  logic [15:0] copy_src;
  logic [15:0] copy_dest;
  logic        cpu_block;
  logic        busy_res;

  modport source (
    output valid, copy_valid, copy_src, copy_dest, cpu_block, busy_res,
    input  ready
  );
  modport sink (
    input  valid, copy_valid, copy_src, copy_dest, cpu_block, busy_res,
    output ready
  );
endinterface

### rtl/core/vdma_step.sv
// Step logic: next transfer state and result for one item.
module vdma_step (
  input  vdma_pkg::state_t    state_i,
  input  vdma_pkg::in_item_t  item_i,
  output vdma_pkg::state_t    state_o,
  output vdma_pkg::out_item_t res_o
);
  import vdma_pkg::*;

  logic            do_copy;
  logic            check_wait;
  logic [LenW-1:0] off_inc;

  assign off_inc = state_i.offset + 12'd1;

  always_comb begin
    state_o    = state_i;
    res_o      = '0;
    do_copy    = 1'b0;
    check_wait = 1'b0;

    if (item_i.mode == ModeStart) begin
      case (item_i.start_kind)
        KindGeneral: state_o.kind = KindGeneral;
        KindHblank:  state_o.kind = KindHblank;
        default:     state_o.kind = KindNone;
      endcase
      state_o.length      = (item_i.length > MaxLength) ? MaxLength : item_i.length;
      state_o.offset      = '0;
      state_o.src_base    = item_i.src_addr;
      state_o.dest_base   = item_i.dest_addr;
      state_o.block_wait  = 1'b0;
      state_o.cpu_blocked = (state_o.kind == KindGeneral);
    end else begin
      case (state_i.kind)
        KindGeneral: do_copy = 1'b1;
        KindHblank: begin
          if (!item_i.cpu_halted) begin
            if (!item_i.ppu_in_hblank) begin
              state_o.block_wait = 1'b0;
            end else if (item_i.lcd_enabled && state_i.block_wait) begin
              state_o.cpu_blocked = 1'b0;
            end else begin
              state_o.cpu_blocked = 1'b1;
              do_copy             = 1'b1;
              check_wait          = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    if (do_copy) begin
      res_o.copy_valid = 1'b1;
      res_o.copy_src   = state_i.src_base + {{(AddrW-LenW){1'b0}}, state_i.offset};
      res_o.copy_dest  = state_i.dest_base + {{(AddrW-LenW){1'b0}}, state_i.offset};
      state_o.offset   = off_inc;
      if (off_inc >= state_i.length) begin
        state_o.cpu_blocked = 1'b0;
        state_o.kind        = KindNone;
      end else if (check_wait && (off_inc % BlockBytes) == '0) begin
        state_o.block_wait = 1'b1;
      end
    end

    res_o.cpu_block = state_o.cpu_blocked;
    res_o.busy_res  = (state_o.kind != KindNone);
  end

endmodule

### rtl/core/vram_dma_general_and_hblank_top.sv
// Top level: video-memory DMA controller with input and result registers.
//
// Video-memory DMA controller for general-purpose and horizontal-blank
// transfers. Each input item is either a start (loads kind, source, destination
// and length; lengths above 2048 saturate, kind 3 means inactive) or a clock
// tick, and every item yields exactly one result item: an optional byte-copy
// request with its wrapped 16-bit source and destination addresses, plus the
// processor-block and busy flags as they stand after that item. Items pass an
// input register, combinational step logic and a result register, so a new
// item is taken every cycle while the result side keeps taking results. An
// accepted item moves from the input register to the result register once
// the result register is free or drains. The transfer state advances when
// an item moves from the input register to the result register, so the next
// item sees it at once. A stalled result side holds the result register and
// the input register; ready drops only when both are full and the result is
// not being taken.
module vram_dma_general_and_hblank_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  vdma_in_if.sink           in_i,
  vdma_out_if.source        out_o
);
  import vdma_pkg::*;

  // Input register
  logic      in_valid_q;
  in_item_t  in_item_q;
  // Result register
  logic      out_valid_q;
  out_item_t out_item_q;
  // Transfer state
  state_t    state_q;
  state_t    state_d;
  out_item_t step_res;

  logic advance;
  logic in_take;

  // Item leaves the input register when the result register is free or drains.
  assign advance = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_take = in_i.valid && in_i.ready;

  vdma_step u_step (
    .state_i (state_q),
    .item_i  (in_item_q),
    .state_o (state_d),
    .res_o   (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.mode          <= in_i.mode;
      in_item_q.start_kind    <= in_i.start_kind;
      in_item_q.src_addr      <= in_i.src_addr;
      in_item_q.dest_addr     <= in_i.dest_addr;
      in_item_q.length        <= in_i.length;
      in_item_q.cpu_halted    <= in_i.cpu_halted;
      in_item_q.ppu_in_hblank <= in_i.ppu_in_hblank;
      in_item_q.lcd_enabled   <= in_i.lcd_enabled;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= step_res;
    end
  end

  // State commits only when the step's result is captured.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{kind: KindNone, default: '0};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.copy_valid = out_item_q.copy_valid;
  assign out_o.copy_src   = out_item_q.copy_src;
  assign out_o.copy_dest  = out_item_q.copy_dest;
  assign out_o.cpu_block  = out_item_q.cpu_block;
  assign out_o.busy_res   = out_item_q.busy_res;

  // Processor can only be blocked by a live transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.cpu_blocked |-> (state_q.kind != KindNone))
    else $error("cpu blocked with no active transfer");

  // An active transfer never runs past its length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.kind != KindNone) |-> (state_q.offset <= state_q.length))
    else $error("offset beyond transfer length");

  // Saturation keeps the stored length in range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.length <= MaxLength)
    else $error("stored length above maximum");

  // Each issued copy advances the offset by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && step_res.copy_valid) |=>
      (state_q.offset == $past(state_q.offset) + 12'd1))
    else $error("offset did not advance with copy");

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// Testbench: directed table and random transfer sequences checked against a predictor.
module testbench;
  import vdma_pkg::*;

  localparam int RandItems  = 500;   // random items, start and tick alike
  localparam int WdLimit    = 2000;  // cycles with no accept on either side
  localparam int HoldCycles = 150;   // the one long result-side stall
  localparam int HoldAt     = 300;   // result count at which it starts
  localparam int DrainWait  = 8;     // settle time after the last result

  // Unused kind code; a start with it reads as inactive.
  localparam logic [1:0] KindReserved = 2'd3;

  // One directed row: an item repeated reps times, with an optional
  // hand-written result that replaces the predicted one.
  typedef struct packed {
    logic [5:0] reps;
    in_item_t   item;
    logic       typed;
    out_item_t  res;
  } stim_row_t;

  typedef struct packed {
    logic      typed;
    out_item_t res;
  } typed_res_t;

  logic clk_i;
  logic rst_ni;

  vdma_in_if  in_if ();
  vdma_out_if out_if ();

  vram_dma_general_and_hblank_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Predictor state: transfer registers as they stand after the last
  // accepted item.
  state_t dma_st;

  stim_row_t  stim_rows[$];
  typed_res_t typed_q[$];          // per offered item, in offer order
  out_item_t  expected_results[$];

  bit tx_idle;
  bit rx_idle;
  int mismatches;
  int idle_cycles;
  int n_items, n_starts, n_saturated, n_copies, n_waits, n_results, n_held;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // One byte copy at the current offset; ends the transfer on the last byte.
  function automatic out_item_t copy_byte(out_item_t r);
    r.copy_valid = 1'b1;
    r.copy_src   = dma_st.src_base + 16'(dma_st.offset);
    r.copy_dest  = dma_st.dest_base + 16'(dma_st.offset);
    dma_st.offset = dma_st.offset + 1'b1;
    if (dma_st.offset >= dma_st.length) begin
      dma_st.cpu_blocked = 1'b0;
      dma_st.kind        = KindNone;
    end
    n_copies++;
    return r;
  endfunction

  function automatic out_item_t predict_step(in_item_t it);
    out_item_t r;
    r = '0;
    if (it.mode == ModeStart) begin
      n_starts++;
      // kind 3 falls back to inactive
      if (it.start_kind == KindGeneral) begin
        dma_st.kind = KindGeneral;
      end else if (it.start_kind == KindHblank) begin
        dma_st.kind = KindHblank;
      end else begin
        dma_st.kind = KindNone;
      end
      if (it.length > MaxLength) begin
        dma_st.length = MaxLength;
        n_saturated++;
      end else begin
        dma_st.length = it.length;
      end
      dma_st.offset      = '0;
      dma_st.src_base    = it.src_addr;
      dma_st.dest_base   = it.dest_addr;
      dma_st.block_wait  = 1'b0;
      dma_st.cpu_blocked = (dma_st.kind == KindGeneral);
    end else if (dma_st.kind == KindGeneral) begin
      r = copy_byte(r);
    end else if (dma_st.kind == KindHblank && !it.cpu_halted) begin
      if (!it.ppu_in_hblank) begin
        dma_st.block_wait = 1'b0;
      end else if (it.lcd_enabled && dma_st.block_wait) begin
        // burst done, waiting for the next blank
        dma_st.cpu_blocked = 1'b0;
      end else begin
        dma_st.cpu_blocked = 1'b1;
        r = copy_byte(r);
        if (dma_st.kind != KindNone && (dma_st.offset % BlockBytes) == '0) begin
          dma_st.block_wait = 1'b1;
          n_waits++;
        end
      end
    end
    r.cpu_block = dma_st.cpu_blocked;
    r.busy_res  = (dma_st.kind != KindNone);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Item helpers
  // ---------------------------------------------------------------------

  function automatic in_item_t mk_item(logic mode, logic [1:0] kind, logic [15:0] src,
                                       logic [15:0] dest, logic [11:0] len,
                                       logic halted, logic hblank, logic lcd);
    in_item_t it;
    it.mode          = mode;
    it.start_kind    = kind;
    it.src_addr      = src;
    it.dest_addr     = dest;
    it.length        = len;
    it.cpu_halted    = halted;
    it.ppu_in_hblank = hblank;
    it.lcd_enabled   = lcd;
    return it;
  endfunction

  function automatic out_item_t mk_result(logic v, logic [15:0] src, logic [15:0] dest,
                                          logic blk, logic busy);
    out_item_t r;
    r.copy_valid = v;
    r.copy_src   = src;
    r.copy_dest  = dest;
    r.cpu_block  = blk;
    r.busy_res   = busy;
    return r;
  endfunction

  function automatic in_item_t rand_item();
    return mk_item(1'($urandom), 2'($urandom), 16'($urandom), 16'($urandom),
                   12'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
  endfunction

  task automatic add_row(int reps, in_item_t it, bit typed, out_item_t r);
    stim_row_t row;
    row.reps  = 6'(reps);
    row.item  = it;
    row.typed = typed;
    row.res   = r;
    stim_rows.push_back(row);
  endtask

  // Offer one item after a random gap and wait until the block takes it.
  // valid stays high between back-to-back items.
  task automatic offer(in_item_t it, bit typed, out_item_t r);
    int gap;
    typed_res_t t;
    gap     = tx_idle ? $urandom_range(0, 10) : 0;
    t.typed = typed;
    t.res   = r;
    typed_q.push_back(t);
    if (gap > 0) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_if.valid         <= 1'b1;
    in_if.mode          <= it.mode;
    in_if.start_kind    <= it.start_kind;
    in_if.src_addr      <= it.src_addr;
    in_if.dest_addr     <= it.dest_addr;
    in_if.length        <= it.length;
    in_if.cpu_halted    <= it.cpu_halted;
    in_if.ppu_in_hblank <= it.ppu_in_hblank;
    in_if.lcd_enabled   <= it.lcd_enabled;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // ---------------------------------------------------------------------
  // Monitor: prediction on input accept, field compare on result accept,
  // watchdog on cycles with neither.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    in_item_t   it;
    out_item_t  got;
    out_item_t  want;
    typed_res_t t;
    bit         acc;
    acc = 1'b0;
    if (rst_ni && in_if.valid && in_if.ready) begin
      acc = 1'b1;
      n_items++;
      it = mk_item(in_if.mode, in_if.start_kind, in_if.src_addr, in_if.dest_addr,
                   in_if.length, in_if.cpu_halted, in_if.ppu_in_hblank, in_if.lcd_enabled);
      want = predict_step(it);
      t    = typed_q.pop_front();
      expected_results.push_back(t.typed ? t.res : want);
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      acc = 1'b1;
      n_results++;
      got = mk_result(out_if.copy_valid, out_if.copy_src, out_if.copy_dest,
                      out_if.cpu_block, out_if.busy_res);
      if (expected_results.size() == 0) begin
        $error("result with no item pending: %h", got);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (got.copy_valid !== want.copy_valid) begin
          $error("copy_valid: expected %0d, got %0d", want.copy_valid, got.copy_valid);
          mismatches++;
        end
        if (got.copy_src !== want.copy_src) begin
          $error("copy_src: expected %h, got %h", want.copy_src, got.copy_src);
          mismatches++;
        end
        if (got.copy_dest !== want.copy_dest) begin
          $error("copy_dest: expected %h, got %h", want.copy_dest, got.copy_dest);
          mismatches++;
        end
        if (got.cpu_block !== want.cpu_block) begin
          $error("cpu_block: expected %0d, got %0d", want.cpu_block, got.cpu_block);
          mismatches++;
        end
        if (got.busy_res !== want.busy_res) begin
          $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
          mismatches++;
        end
      end
    end
    if (!rst_ni || acc) begin
      idle_cycles = 0;
    end else if (idle_cycles == WdLimit) begin
      $display("Timeout: no item moved for %0d cycles", WdLimit);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  // ---------------------------------------------------------------------
  // Result side: random stalls per item, quiet stretches, and one long
  // hold-off so the input and result registers fill and ready drops.
  // ---------------------------------------------------------------------
  initial begin
    int gap;
    int seen;
    bit held;
    seen = 0;
    held = 1'b0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (seen % 40 == 0) rx_idle = $urandom_range(0, 2) != 0;
      gap = rx_idle ? $urandom_range(0, 10) : 0;
      if (seen == HoldAt && !held) begin
        gap    = HoldCycles;
        held   = 1'b1;
        n_held = HoldCycles;
      end
      if (gap > 0) begin
        @(negedge clk_i);
        out_if.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      seen++;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin
    in_item_t it;
    int       kind_pick;
    int       span;
    int       n_ticks;
    int       n_random;

    in_if.valid = 1'b0;
    {in_if.mode, in_if.start_kind, in_if.src_addr, in_if.dest_addr, in_if.length,
     in_if.cpu_halted, in_if.ppu_in_hblank, in_if.lcd_enabled} = '0;
    dma_st = '0;
    rst_ni = 1'b0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;

    // Directed part. Ticks carry all-ones start fields where those must be
    // ignored.
    // Kind 3 start reads as inactive; a tick then does nothing.
    add_row(1, mk_item(ModeStart, KindReserved, 16'h1234, 16'h5678, 12'd5, 1'b0, 1'b0, 1'b0),
            1, mk_result(1'b0, 16'h0, 16'h0, 1'b0, 1'b0));
    add_row(1, mk_item(ModeTick, KindReserved, 16'hFFFF, 16'hFFFF, 12'hFFF, 1'b1, 1'b1, 1'b1),
            1, mk_result(1'b0, 16'h0, 16'h0, 1'b0, 1'b0));
    // Zero-length general transfer still copies one byte, then ends.
    add_row(1, mk_item(ModeStart, KindGeneral, 16'hFFFF, 16'hFFFF, 12'd0, 1'b0, 1'b0, 1'b0),
            1, mk_result(1'b0, 16'h0, 16'h0, 1'b1, 1'b1));
    add_row(1, mk_item(ModeTick, KindNone, 16'h0, 16'h0, 12'd0, 1'b1, 1'b0, 1'b0),
            1, mk_result(1'b1, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0));
    // Address wrap past 0xFFFF on a three-byte general transfer.
    add_row(1, mk_item(ModeStart, KindGeneral, 16'hFFFE, 16'h0001, 12'd3, 1'b0, 1'b0, 1'b0),
            1, mk_result(1'b0, 16'h0, 16'h0, 1'b1, 1'b1));
    add_row(3, mk_item(ModeTick, KindReserved, 16'hFFFF, 16'hFFFF, 12'hFFF, 1'b0, 1'b0, 1'b0),
            0, '0);
    // Longest length field saturates; one byte copied.
    add_row(1, mk_item(ModeStart, KindGeneral, 16'h0000, 16'h0000, 12'hFFF, 1'b1, 1'b1, 1'b1),
            1, mk_result(1'b0, 16'h0, 16'h0, 1'b1, 1'b1));
    add_row(1, mk_item(ModeTick, KindNone, 16'h0, 16'h0, 12'd0, 1'b0, 1'b0, 1'b0), 0, '0);
    // Blank start mid-transfer drops the processor block.
    add_row(1, mk_item(ModeStart, KindHblank, 16'h8000, 16'h9FF0, 12'd18, 1'b0, 1'b0, 1'b0),
            1, mk_result(1'b0, 16'h0, 16'h0, 1'b0, 1'b1));
    // Halted processor: no change.
    add_row(1, mk_item(ModeTick, KindNone, 16'h0, 16'h0, 12'd0, 1'b1, 1'b1, 1'b1),
            1, mk_result(1'b0, 16'h0, 16'h0, 1'b0, 1'b1));
    // Outside blank: nothing copied.
    add_row(1, mk_item(ModeTick, KindNone, 16'h0, 16'h0, 12'd0, 1'b0, 1'b0, 1'b1),
            1, mk_result(1'b0, 16'h0, 16'h0, 1'b0, 1'b1));
    // One full burst, then the wait with the LCD on.
    add_row(16, mk_item(ModeTick, KindNone, 16'h0, 16'h0, 12'd0, 1'b0, 1'b1, 1'b1), 0, '0);
    add_row(1, mk_item(ModeTick, KindNone, 16'h0, 16'h0, 12'd0, 1'b0, 1'b1, 1'b1), 0, '0);
    // LCD off ignores the wait flag, which stays set.
    add_row(1, mk_item(ModeTick, KindNone, 16'h0, 16'h0, 12'd0, 1'b0, 1'b1, 1'b0), 0, '0);
    add_row(1, mk_item(ModeTick, KindNone, 16'h0, 16'h0, 12'd0, 1'b0, 1'b1, 1'b1), 0, '0);
    // Leaving blank clears the wait; the last byte ends the transfer.
    add_row(1, mk_item(ModeTick, KindNone, 16'h0, 16'h0, 12'd0, 1'b0, 1'b0, 1'b1), 0, '0);
    add_row(1, mk_item(ModeTick, KindNone, 16'h0, 16'h0, 12'd0, 1'b0, 1'b1, 1'b1), 0, '0);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (stim_rows[i]) begin
      repeat (int'(stim_rows[i].reps)) begin
        offer(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].res);
      end
    end

    // Random part: mostly a start followed by a run of ticks with random
    // blank, halt and LCD bits; a few items are fully random noise.
    n_random = 0;
    while (n_random < RandItems) begin
      kind_pick = $urandom_range(0, 15);
      it = rand_item();
      it.mode = ModeStart;
      if (kind_pick == 0) begin
        it.start_kind = KindNone;
      end else if (kind_pick == 1) begin
        it.start_kind = KindReserved;
      end else if (kind_pick < 9) begin
        it.start_kind = KindGeneral;
      end else begin
        it.start_kind = KindHblank;
      end
      // short lengths mostly; the full field now and then
      if ($urandom_range(0, 7) != 0) it.length = 12'($urandom_range(0, 40));
      tx_idle = $urandom_range(0, 2) != 0;
      offer(it, 1'b0, '0);
      n_random++;
      span    = (it.length > 50) ? 50 : int'(it.length);
      n_ticks = $urandom_range(span / 2, span + 10);
      repeat (n_ticks) begin
        it = rand_item();
        if ($urandom_range(0, 11) != 0) begin
          it.mode          = ModeTick;
          it.cpu_halted    = $urandom_range(0, 7) == 0;
          it.ppu_in_hblank = $urandom_range(0, 3) != 0;
          it.lcd_enabled   = $urandom_range(0, 3) != 0;
        end
        offer(it, 1'b0, '0);
        n_random++;
      end
    end

    @(negedge clk_i);
    in_if.valid <= 1'b0;

    // Drain; the watchdog bounds this wait.
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      mismatches++;
    end

    $display("Summary: %0d items (%0d starts, %0d saturated lengths), %0d results compared",
             n_items, n_starts, n_saturated, n_results);
    $display("Summary: %0d byte copies, %0d burst waits, one %0d-cycle result stall",
             n_copies, n_waits, n_held);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
